>>> src/dsdf_pkg.sv
// Shared types, constants and helper functions for the score display formatter.
`timescale 1ns / 1ps
`default_nettype none

package dsdf_pkg;

    localparam int SCORE_W = 16;
    localparam int COUNT_W = 4;
    localparam int CODE_W  = 4;
    localparam int ADDR_W  = 4;

    localparam logic [CODE_W-1:0] BLANK_CODE = 4'd15;

    // x / 10 == (x * 0xCCCD) >> 19 holds exactly for every 16-bit x.
    localparam logic [16:0] DIV10_MULT  = 17'h0CCCD;
    localparam int          DIV10_SHIFT = 19;

    // Saturated score together with the number of digits that are shown.
    typedef struct packed {
        logic [SCORE_W-1:0] value;
        logic [COUNT_W-1:0] count;
    } score_prep_t;

    // Ten to the power n, for n from 0 to 8.
    function automatic logic [31:0] pow10(input int n);
        logic [31:0] r;
        r = 32'd1;
        for (int i = 0; i < 8; i++) begin
            if (i < n) begin
                r = r * 32'd10;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/dsdf_score_prep.sv
// Score saturation and shown-digit count for one binary score.
`timescale 1ns / 1ps
`default_nettype none

module dsdf_score_prep #(
    parameter int DIGITS_PER_SCORE = 4
) (
    input  wire logic [dsdf_pkg::SCORE_W-1:0] score,
    output dsdf_pkg::score_prep_t             prep
);

    logic [31:0]                 score_wide;
    logic [dsdf_pkg::COUNT_W-1:0] count;

    assign score_wide = 32'(score);

    // A saturated score is all nines, so the compares below give the full count for it too.
    always_comb begin
        count = dsdf_pkg::COUNT_W'(1);
        for (int i = 1; i < DIGITS_PER_SCORE; i++) begin
            if (score_wide >= dsdf_pkg::pow10(i)) begin
                count = count + dsdf_pkg::COUNT_W'(1);
            end
        end
        if (score_wide >= dsdf_pkg::pow10(DIGITS_PER_SCORE)) begin
            prep.value = dsdf_pkg::SCORE_W'(dsdf_pkg::pow10(DIGITS_PER_SCORE) - 32'd1);
        end else begin
            prep.value = score;
        end
        prep.count = count;
    end

endmodule

`default_nettype wire

>>> src/dual_score_decimal_display_formatter_core.sv
// Top level of the dual score decimal display formatter.
// An accepted input word is held in the job register, and its display words move from there into the output register.
// Each input word yields 2*DIGITS_PER_SCORE display words, one per cycle unless the receiver stalls the
// output, all through the single output register and the one shared divide-by-ten unit that feeds it;
// a new input word is taken in the cycle in which the last display word of the previous one is loaded.
// Reset: aresetn is synchronous and active low; it empties the job and output registers.
`timescale 1ns / 1ps
`default_nettype none

module dual_score_decimal_display_formatter_core #(
    parameter int DIGITS_PER_SCORE = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Input words: [15:0] score_left, [31:16] score_right.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,

    // Display words: [3:0] digit_address, [7:4] digit_code. last_write travels as m_tlast.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    localparam int TOTAL = 2 * DIGITS_PER_SCORE;
    localparam int KW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;

    // Front end: saturate each score and count the digits it shows. This is cheap
    // compare logic, so it sits directly in front of the job register.
    dsdf_pkg::score_prep_t prep_left;
    dsdf_pkg::score_prep_t prep_right;

    dsdf_score_prep #(
        .DIGITS_PER_SCORE(DIGITS_PER_SCORE)
    ) u_prep_left (
        .score(s_tdata[15:0]),
        .prep (prep_left)
    );

    dsdf_score_prep #(
        .DIGITS_PER_SCORE(DIGITS_PER_SCORE)
    ) u_prep_right (
        .score(s_tdata[31:16]),
        .prep (prep_right)
    );

    // Job register: the score being emitted. The remaining values shrink by a factor
    // of ten each time one of their digits goes out, so digits come out least
    // significant first, which matches the address order for both scores.
    logic                          job_valid_reg;
    logic [KW-1:0]                 k_reg;
    logic [dsdf_pkg::SCORE_W-1:0]  rv_reg;
    logic [dsdf_pkg::SCORE_W-1:0]  lv_reg;
    logic [dsdf_pkg::COUNT_W-1:0]  nr_reg;
    logic [dsdf_pkg::COUNT_W-1:0]  nl_reg;

    // Output register.
    logic                          out_valid_reg;
    logic [dsdf_pkg::ADDR_W-1:0]   out_addr_reg;
    logic [dsdf_pkg::CODE_W-1:0]   out_code_reg;
    logic                          out_last_reg;

    logic                          load_out;
    logic                          job_done;
    logic                          accept_in;
    logic                          right_phase;
    logic                          is_blank;
    logic [4:0]                    k_wide;
    logic [dsdf_pkg::SCORE_W-1:0]  cur_value;
    logic [32:0]                   product;
    logic [dsdf_pkg::SCORE_W-1:0]  quotient;
    logic [dsdf_pkg::SCORE_W-1:0]  quotient_x10;
    logic [dsdf_pkg::SCORE_W-1:0]  remainder;
    logic [7:0]                    addr_wide;

    // A word moves into the output register whenever that register is empty or
    // its current word is taken in this cycle.
    assign load_out  = job_valid_reg && (!out_valid_reg || m_tready);
    assign job_done  = load_out && (k_reg == KW'(TOTAL - 1));
    assign s_tready  = !job_valid_reg || job_done;
    assign accept_in = s_tvalid && s_tready;

    assign k_wide      = 5'(k_reg);
    assign right_phase = k_reg < KW'(DIGITS_PER_SCORE);

    // Right score: digits at or above its count are blank. Left score: it is
    // left-aligned, so its lowest (DIGITS_PER_SCORE - count) addresses are blank.
    always_comb begin
        if (right_phase) begin
            is_blank = k_wide >= {1'b0, nr_reg};
        end else begin
            is_blank = k_wide < (5'(TOTAL) - {1'b0, nl_reg});
        end
    end

    // Shared divide-by-ten by reciprocal multiplication.
    assign cur_value    = right_phase ? rv_reg : lv_reg;
    assign product      = {17'b0, cur_value} * {16'b0, dsdf_pkg::DIV10_MULT};
    assign quotient     = dsdf_pkg::SCORE_W'(product >> dsdf_pkg::DIV10_SHIFT);
    assign quotient_x10 = (quotient << 3) + (quotient << 1);
    assign remainder    = cur_value - quotient_x10;

    assign addr_wide = 8'(k_reg) + 8'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
            k_reg         <= '0;
        end else begin
            if (accept_in) begin
                job_valid_reg <= 1'b1;
                k_reg         <= '0;
            end else if (job_done) begin
                job_valid_reg <= 1'b0;
            end else if (load_out) begin
                k_reg <= k_reg + KW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_in) begin
            rv_reg <= prep_right.value;
            lv_reg <= prep_left.value;
            nr_reg <= prep_right.count;
            nl_reg <= prep_left.count;
        end else if (load_out && !is_blank) begin
            if (right_phase) begin
                rv_reg <= quotient;
            end else begin
                lv_reg <= quotient;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_addr_reg <= addr_wide[3:0];
            out_code_reg <= is_blank ? dsdf_pkg::BLANK_CODE : remainder[3:0];
            out_last_reg <= (k_reg == KW'(TOTAL - 1));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_code_reg, out_addr_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the dual score display formatter: directed table, then random words.
`timescale 1ns / 1ps

module tb_top;

    // The block runs with its default of four digits per score, so a score
    // saturates at 9999 and every input word yields eight display words.
    localparam int DIGITS         = 4;
    localparam int SCORE_LIMIT    = 10000;
    localparam int WRITES_PER_RUN = 2 * DIGITS;
    localparam int RANDOM_WORDS   = 400;
    localparam int DIRECTED_ROWS  = 20;
    // The longest quiet stretch of a correct run is the receiver's long
    // hold-off (HOLDOFF_CYCLES); the watchdog allows several times that.
    localparam int HOLDOFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    // The first display word passes the job and output registers after its
    // input word is taken; the drain at the end waits well beyond that.
    localparam int DRAIN_CYCLES   = 30;

    // One display word as it should appear on the result channel.
    typedef struct packed {
        logic [dsdf_pkg::ADDR_W-1:0] addr;
        logic [dsdf_pkg::CODE_W-1:0] code;
        logic                        last;
    } display_write_t;

    // A score split into decimal digits, least significant nibble first,
    // together with the number of digits that are shown.
    typedef struct packed {
        logic [3:0]  shown;
        logic [15:0] digs;
    } dec_score_t;

    // One row of the directed table. Where typed is set, codes holds the
    // expected display, address 1 in the lowest nibble and address 8 in the
    // highest; otherwise the predictor works the display out.
    typedef struct packed {
        logic [dsdf_pkg::SCORE_W-1:0] left;
        logic [dsdf_pkg::SCORE_W-1:0] right;
        logic                         typed;
        logic [31:0]                  codes;
    } score_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    // Display words that are owed by the block, oldest first.
    display_write_t pending_writes[$];
    int             mismatch_count = 0;
    int             idle_cycles    = 0;

    score_row_t directed_table [DIRECTED_ROWS];

    dual_score_decimal_display_formatter_core #(
        .DIGITS_PER_SCORE(DIGITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Splits a score into its decimal digits. A score at or above the limit
    // shows every digit as 9; otherwise the shown count reaches up to the
    // highest nonzero digit, and a score of zero still shows one digit.
    function automatic dec_score_t to_decimal(input logic [dsdf_pkg::SCORE_W-1:0] score);
        dec_score_t  r;
        int unsigned v;
        v = score;
        r.digs  = '0;
        r.shown = 4'd1;
        if (v >= SCORE_LIMIT) begin
            r.digs  = 16'h9999;
            r.shown = 4'(DIGITS);
        end else begin
            for (int i = 0; i < DIGITS; i++) begin
                r.digs[4*i +: 4] = 4'(v % 10);
                v = v / 10;
                if (r.digs[4*i +: 4] != 4'd0) begin
                    r.shown = 4'(i + 1);
                end
            end
        end
        return r;
    endfunction

    // Works out the eight digit codes of one input word. The right score is
    // right-aligned at the bottom addresses; the left score is left-aligned so
    // that its top shown digit lands on the highest address.
    function automatic logic [31:0] format_scores(
        input logic [dsdf_pkg::SCORE_W-1:0] left,
        input logic [dsdf_pkg::SCORE_W-1:0] right
    );
        dec_score_t  l;
        dec_score_t  r;
        logic [31:0] codes;
        int          src;
        l = to_decimal(left);
        r = to_decimal(right);
        for (int k = 0; k < DIGITS; k++) begin
            codes[4*k +: 4] = (k < int'(r.shown)) ? r.digs[4*k +: 4] : dsdf_pkg::BLANK_CODE;
            src = k - (DIGITS - int'(l.shown));
            codes[4*(DIGITS + k) +: 4] = (src >= 0) ? l.digs[4*src +: 4]
                                                    : dsdf_pkg::BLANK_CODE;
        end
        return codes;
    endfunction

    // Queues the eight display words that one accepted input word owes.
    function automatic void queue_display(input logic [31:0] codes);
        display_write_t w;
        for (int k = 0; k < WRITES_PER_RUN; k++) begin
            w.addr = dsdf_pkg::ADDR_W'(k + 1);
            w.code = codes[4*k +: 4];
            w.last = (k == WRITES_PER_RUN - 1);
            pending_writes.push_back(w);
        end
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t ns: display word %s is %0d, expected %0d", $time, field, got, want);
        mismatch_count++;
    endtask

    task automatic report_stray(input int addr, input int code);
        $display("%0t ns: display word with none owed, address %0d code %0d",
                 $time, addr, code);
        mismatch_count++;
    endtask

    // Picks a score from a mix of classes: the saturation boundary, the
    // decimal boundaries where blanking changes, small values, and the full
    // 16-bit range so that every bit is exercised.
    function automatic logic [dsdf_pkg::SCORE_W-1:0] pick_score();
        int unsigned p;
        case ($urandom_range(0, 7))
            0: pick_score = '0;
            1, 2: pick_score = dsdf_pkg::SCORE_W'($urandom);
            3: pick_score = dsdf_pkg::SCORE_W'($urandom_range(0, SCORE_LIMIT - 1));
            4: pick_score = dsdf_pkg::SCORE_W'($urandom_range(0, 99));
            5: pick_score = dsdf_pkg::SCORE_W'($urandom_range(SCORE_LIMIT - 10,
                                                              SCORE_LIMIT + 10));
            6: begin
                p = 1;
                repeat ($urandom_range(0, 3)) p = p * 10;
                pick_score = dsdf_pkg::SCORE_W'(p + $urandom_range(0, 2) - 1);
            end
            default: pick_score = dsdf_pkg::SCORE_W'($urandom_range(SCORE_LIMIT, 65535));
        endcase
    endfunction

    // Offers one input word and holds it until it is taken. The word is
    // accepted at the edge where tvalid and tready were both high, and the
    // expected display words are queued at that same edge.
    task automatic offer_scores(input logic [dsdf_pkg::SCORE_W-1:0] left,
                                input logic [dsdf_pkg::SCORE_W-1:0] right,
                                input logic [31:0]                  codes);
        s_tvalid <= 1'b1;
        s_tdata  <= {right, left};
        do @(posedge aclk); while (!s_tready);
        queue_display(codes);
    endtask

    // Called at the edge where a word was accepted. Bursts of random length
    // run back to back; between bursts tvalid drops for a random gap. Some
    // bursts are followed by no gap at all.
    int burst_left = 0;
    task automatic sender_pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Drops tvalid and waits until every owed display word has arrived. At
    // least one edge passes, so tvalid is never lowered and raised in one step.
    task automatic sender_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_writes.size() != 0);
    endtask

    // Stimulus: reset, the directed table, then the random words.
    initial begin
        logic [31:0]                  codes;
        logic [dsdf_pkg::SCORE_W-1:0] left;
        logic [dsdf_pkg::SCORE_W-1:0] right;

        // Rows with a typed display: both scores zero, both at the largest
        // value, both just under the limit, both at it, and one side saturated
        // while the other is zero.
        directed_table = '{
            '{16'd0,     16'd0,     1'b1, 32'h0FFF_FFF0},
            '{16'd65535, 16'd65535, 1'b1, 32'h9999_9999},
            '{16'd9999,  16'd9999,  1'b1, 32'h9999_9999},
            '{16'd10000, 16'd10000, 1'b1, 32'h9999_9999},
            '{16'd10000, 16'd0,     1'b1, 32'h9999_FFF0},
            '{16'd0,     16'd65535, 1'b1, 32'h0FFF_9999},
            '{16'd1,     16'd1,     1'b0, 32'h0},
            '{16'd9,     16'd10,    1'b0, 32'h0},
            '{16'd99,    16'd100,   1'b0, 32'h0},
            '{16'd999,   16'd1000,  1'b0, 32'h0},
            '{16'd1000,  16'd999,   1'b0, 32'h0},
            '{16'd1234,  16'd5678,  1'b0, 32'h0},
            '{16'd7,     16'd0,     1'b0, 32'h0},
            '{16'd0,     16'd7,     1'b0, 32'h0},
            '{16'd10,    16'd1,     1'b0, 32'h0},
            '{16'd9998,  16'd10001, 1'b0, 32'h0},
            '{16'hAAAA,  16'h5555,  1'b0, 32'h0},
            '{16'h5555,  16'hAAAA,  1'b0, 32'h0},
            '{16'd100,   16'd1010,  1'b0, 32'h0},
            '{16'd5005,  16'd9090,  1'b0, 32'h0}
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            left  = directed_table[i].left;
            right = directed_table[i].right;
            codes = directed_table[i].typed ? directed_table[i].codes
                                            : format_scores(left, right);
            offer_scores(left, right, codes);
            sender_pace();
        end

        // Let the pipeline run empty once before the random part.
        sender_drain();

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            left  = pick_score();
            right = pick_score();
            offer_scores(left, right, format_scores(left, right));
            if (i == RANDOM_WORDS / 2) begin
                sender_drain();
            end else begin
                sender_pace();
            end
        end

        // Wait for the last display words, then give the block time to show
        // any stray word it should not produce.
        sender_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_writes.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Receiver: checks each accepted display word against the oldest owed
    // one, then decides tready for the next cycle. Short stalls follow a mode
    // that changes after a random stretch; once, after fifty input words have
    // been shown, tready stays low for a long hold-off so the block fills up
    // and has to stall its input while the sender keeps offering words.
    initial begin
        display_write_t want;
        int             results_seen;
        int             holdoff_left;
        bit             held;
        int             mode_left;
        int             stall_mode;
        logic [7:0]     stall_pattern;
        logic           ready;

        results_seen  = 0;
        holdoff_left  = 0;
        held          = 1'b0;
        mode_left     = 0;
        stall_mode    = 0;
        stall_pattern = 8'hFF;

        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                results_seen++;
                if (pending_writes.size() == 0) begin
                    report_stray(m_tdata[3:0], m_tdata[7:4]);
                end else begin
                    want = pending_writes.pop_front();
                    if (m_tdata[3:0] != want.addr) begin
                        report_mismatch("address", m_tdata[3:0], want.addr);
                    end
                    if (m_tdata[7:4] != want.code) begin
                        report_mismatch("code", m_tdata[7:4], want.code);
                    end
                    if (m_tlast != want.last) begin
                        report_mismatch("last flag", m_tlast, want.last);
                    end
                end
            end

            if (holdoff_left > 0) begin
                holdoff_left--;
                ready = 1'b0;
            end else if (!held && results_seen >= 50 * WRITES_PER_RUN) begin
                held         = 1'b1;
                holdoff_left = HOLDOFF_CYCLES - 1;
                ready        = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode_left     = $urandom_range(16, 96);
                    stall_mode    = $urandom_range(0, 3);
                    stall_pattern = 8'($urandom);
                end
                mode_left--;
                case (stall_mode)
                    0: ready = 1'b1;
                    1: ready = 1'($urandom_range(0, 1));
                    2: ready = ($urandom_range(0, 3) == 0);
                    default: begin
                        ready         = stall_pattern[0];
                        stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
                    end
                endcase
            end
            m_tready <= ready;
        end
    end

    // Watchdog: counts cycles in which neither channel moves a word. A block
    // that hangs ends the run here.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t ns: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

>>> sim.f
src/dsdf_pkg.sv
src/dsdf_score_prep.sv
src/dual_score_decimal_display_formatter_core.sv
bench/tb_top.sv
